>>> rtl/core/akpd_pkg.sv
package akpd_pkg;

  localparam int unsigned AdcW  = 10;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HoldW = 16;
  localparam int unsigned KeyW  = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [KeyW-1:0] KEY_0  = 2'd0;
  localparam logic [KeyW-1:0] KEY_1  = 2'd1;
  localparam logic [KeyW-1:0] KEY_2  = 2'd2;
  localparam logic [KeyW-1:0] NO_KEY = 2'd3;

  localparam logic MODE_DEFAULT = 1'b0;
  localparam logic MODE_BRIGHT  = 1'b1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_KEY0_LOW  = 3'd0,
    REG_KEY0_HIGH = 3'd1,
    REG_KEY1_LOW  = 3'd2,
    REG_KEY1_HIGH = 3'd3,
    REG_KEY2_LOW  = 3'd4,
    REG_KEY2_HIGH = 3'd5,
    REG_LONG_MS   = 3'd6,
    REG_POLL_MS   = 3'd7
  } cfg_reg_e;

  localparam logic [AdcW-1:0]  KEY0_LOW_RST  = 10'd214;
  localparam logic [AdcW-1:0]  KEY0_HIGH_RST = 10'd254;
  localparam logic [AdcW-1:0]  KEY1_LOW_RST  = 10'd19;
  localparam logic [AdcW-1:0]  KEY1_HIGH_RST = 10'd50;
  localparam logic [AdcW-1:0]  KEY2_LOW_RST  = 10'd680;
  localparam logic [AdcW-1:0]  KEY2_HIGH_RST = 10'd800;
  localparam logic [HoldW-1:0] LONG_MS_RST   = 16'd1000;
  localparam logic [AdcW-1:0]  POLL_MS_RST   = 10'd10;

  typedef struct packed {
    logic [AdcW-1:0]  key0_low;
    logic [AdcW-1:0]  key0_high;
    logic [AdcW-1:0]  key1_low;
    logic [AdcW-1:0]  key1_high;
    logic [AdcW-1:0]  key2_low;
    logic [AdcW-1:0]  key2_high;
    logic [HoldW-1:0] long_ms;
    logic [AdcW-1:0]  poll_ms;
  } akpd_cfg_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            long_press;
    logic            event_mode;
    logic            mode_after;
  } akpd_event_t;

endpackage

>>> rtl/core/akpd_classify.sv
module akpd_classify (
  input  logic [akpd_pkg::AdcW-1:0] sample_i,
  input  akpd_pkg::akpd_cfg_t       cfg_i,
  output logic [akpd_pkg::KeyW-1:0] key_o
);
  import akpd_pkg::*;

  logic hit0, hit1, hit2;

  // exclusive bounds on both sides
  assign hit0 = (sample_i > cfg_i.key0_low) && (sample_i < cfg_i.key0_high);
  assign hit1 = (sample_i > cfg_i.key1_low) && (sample_i < cfg_i.key1_high);
  assign hit2 = (sample_i > cfg_i.key2_low) && (sample_i < cfg_i.key2_high);

  // key 2 has priority, then key 0, then key 1
  always_comb begin
    if (hit2) begin
      key_o = KEY_2;
    end else if (hit0) begin
      key_o = KEY_0;
    end else if (hit1) begin
      key_o = KEY_1;
    end else begin
      key_o = NO_KEY;
    end
  end

endmodule

>>> rtl/core/akpd_tracker.sv
module akpd_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [akpd_pkg::AdcW-1:0]  sample_i,
  input  logic [akpd_pkg::TimeW-1:0] now_i,
  input  akpd_pkg::akpd_cfg_t        cfg_i,
  output akpd_pkg::akpd_event_t      event_o
);
  import akpd_pkg::*;

  logic [TimeW-1:0] last_poll_q, last_poll_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic [KeyW-1:0]  held_key_q, held_key_d;
  logic             long_rep_q, long_rep_d;
  logic             mode_q, mode_d;

  logic [KeyW-1:0]  key;
  logic [TimeW-1:0] since_poll;
  logic [TimeW-1:0] hold_time;
  logic             early;
  logic             press, release_ev, short_ev, long_ev;

  akpd_classify u_classify (
    .sample_i (sample_i),
    .cfg_i    (cfg_i),
    .key_o    (key)
  );

  assign since_poll = now_i - last_poll_q;
  assign hold_time  = now_i - press_start_q;
  assign early      = since_poll < {{(TimeW-AdcW){1'b0}}, cfg_i.poll_ms};

  assign press      = (key != NO_KEY) && (held_key_q == NO_KEY);
  assign release_ev = (key == NO_KEY) && (held_key_q != NO_KEY);
  assign short_ev   = release_ev && !long_rep_q &&
                      (hold_time <= {{(TimeW-HoldW){1'b0}}, cfg_i.long_ms});
  // a fresh press has no held key yet, so it can never be long in the same poll
  assign long_ev    = (key != NO_KEY) && (key == held_key_q) && !long_rep_q &&
                      (hold_time > {{(TimeW-HoldW){1'b0}}, cfg_i.long_ms});

  always_comb begin
    event_o            = '0;
    event_o.valid      = step_i && !early && (short_ev || long_ev);
    event_o.key        = held_key_q;
    event_o.long_press = long_ev;
    event_o.event_mode = mode_q;
    event_o.mode_after = mode_q;
    if (held_key_q == KEY_0) begin
      event_o.mode_after = long_ev ? MODE_DEFAULT : MODE_BRIGHT;
    end
  end

  always_comb begin
    last_poll_d   = last_poll_q;
    press_start_d = press_start_q;
    held_key_d    = held_key_q;
    long_rep_d    = long_rep_q;
    mode_d        = mode_q;
    if (step_i && !early) begin
      last_poll_d = now_i;
      if (press) begin
        held_key_d    = key;
        press_start_d = now_i;
        long_rep_d    = 1'b0;
      end
      if (release_ev) begin
        held_key_d = NO_KEY;
      end
      if (long_ev) begin
        long_rep_d = 1'b1;
      end
      if (event_o.valid) begin
        mode_d = event_o.mode_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q   <= '0;
      press_start_q <= '0;
      held_key_q    <= NO_KEY;
      long_rep_q    <= 1'b0;
      mode_q        <= MODE_DEFAULT;
    end else begin
      last_poll_q   <= last_poll_d;
      press_start_q <= press_start_d;
      held_key_q    <= held_key_d;
      long_rep_q    <= long_rep_d;
      mode_q        <= mode_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_event_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid |-> event_o.key != NO_KEY)
    else $error("event raised without a held key");

  a_long_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.long_press) |=> long_rep_q)
    else $error("long press not recorded");

  a_short_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && !event_o.long_press) |=> held_key_q == NO_KEY)
    else $error("short press left a key held");

  a_early_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && early) |=> ($stable(last_poll_q) && $stable(held_key_q) &&
                           $stable(mode_q)))
    else $error("early sample changed state");

  a_mode_only_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !event_o.valid |=> $stable(mode_q))
    else $error("mode changed without an event");
`endif

endmodule

>>> rtl/core/adc_ladder_key_press_detector.sv
// Resistor-ladder keypad press detector.
// Input stream: one transaction per ADC poll, carrying the 10-bit ladder
// sample and a 32-bit millisecond timestamp. Samples closer than the poll
// interval to the last accepted poll are dropped silently.
// Output stream: one transaction per key event, short press on release or
// long press once while held, with the keyboard mode before and after it.
// Configuration: eight registers written through cfg_we_i/cfg_addr_i/
// cfg_wdata_i; write them only while no transaction is in flight.
// An event is computed from the input register and registered in the output
// register. Throughput: one input transaction per cycle while the output
// register is free, set by the single input register feeding the state update.
// Stall: while the output register holds an event that m_axis_tready has
// not taken, the item in the input register waits and s_axis_tready stays
// low once that register is full.
// Reset: registers return to their default windows and thresholds, no key
// is held, the mode is default and both stream registers are emptied.
module adc_ladder_key_press_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [akpd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [akpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // adc_sample[9:0], now_ms[41:10]
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // event_key[1:0], event_mode[2],
                                                       // mode_after[3]
  output logic                          m_axis_tuser   // long_press
);
  import akpd_pkg::*;

  akpd_cfg_t        cfg_q;
  logic             in_valid_q;
  logic [AdcW-1:0]  in_sample_q;
  logic [TimeW-1:0] in_now_q;
  logic             out_valid_q;
  akpd_event_t      out_q;
  akpd_event_t      evt;
  logic             out_free, step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key0_low  <= KEY0_LOW_RST;
      cfg_q.key0_high <= KEY0_HIGH_RST;
      cfg_q.key1_low  <= KEY1_LOW_RST;
      cfg_q.key1_high <= KEY1_HIGH_RST;
      cfg_q.key2_low  <= KEY2_LOW_RST;
      cfg_q.key2_high <= KEY2_HIGH_RST;
      cfg_q.long_ms   <= LONG_MS_RST;
      cfg_q.poll_ms   <= POLL_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_KEY0_LOW:  cfg_q.key0_low  <= cfg_wdata_i[AdcW-1:0];
        REG_KEY0_HIGH: cfg_q.key0_high <= cfg_wdata_i[AdcW-1:0];
        REG_KEY1_LOW:  cfg_q.key1_low  <= cfg_wdata_i[AdcW-1:0];
        REG_KEY1_HIGH: cfg_q.key1_high <= cfg_wdata_i[AdcW-1:0];
        REG_KEY2_LOW:  cfg_q.key2_low  <= cfg_wdata_i[AdcW-1:0];
        REG_KEY2_HIGH: cfg_q.key2_high <= cfg_wdata_i[AdcW-1:0];
        REG_LONG_MS:   cfg_q.long_ms   <= cfg_wdata_i[HoldW-1:0];
        REG_POLL_MS:   cfg_q.poll_ms   <= cfg_wdata_i[AdcW-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // advance the held item when the output register can take a result
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[AdcW-1:0];
      in_now_q    <= s_axis_tdata[AdcW+TimeW-1:AdcW];
    end
  end

  akpd_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_sample_q),
    .now_i    (in_now_q),
    .cfg_i    (cfg_q),
    .event_o  (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && evt.valid) begin
      out_q <= evt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.mode_after, out_q.event_mode, out_q.key};
  assign m_axis_tuser  = out_q.long_press;

endmodule
